/* rtl/core/bpu_pkg.sv */
`default_nettype none

package bpu_pkg;

  localparam logic [1:0] MODE_PAL_WRITE = 2'd0;
  localparam logic [1:0] MODE_DATA      = 2'd1;
  localparam logic [1:0] MODE_START     = 2'd2;

  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_16BPP = 3'd3;
  localparam logic [2:0] FMT_24BPP = 3'd4;
  localparam logic [2:0] FMT_32BPP = 3'd5;

  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_IMAGE_WIDTH  = 1'b1;

  localparam logic [2:0] PIXEL_FORMAT_RESET = FMT_32BPP;
  localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd1;

  localparam logic [1:0] KIND_PAL_WRITE = 2'd0;
  localparam logic [1:0] KIND_PAL_PIX   = 2'd1;
  localparam logic [1:0] KIND_DIRECT    = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [12:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  fmt;
    logic [3:0]  count;
    logic        row_end;
    logic        alpha;
    logic [7:0]  addr;
    logic [31:0] data;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/bpu_in_if.sv */
`default_nettype none

interface bpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  palette_index;
  logic [31:0] palette_word;
  logic [7:0]  data_byte;

  modport source (output valid, mode, palette_index, palette_word, data_byte, input ready);
  modport sink (input valid, mode, palette_index, palette_word, data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/bpu_out_if.sv */
`default_nettype none

interface bpu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        row_end;
  logic        last_of_item;
  logic        alpha_seen;

  modport source (output valid, pixel_argb, row_end, last_of_item, alpha_seen, input ready);
  modport sink (input valid, pixel_argb, row_end, last_of_item, alpha_seen, output ready);
endinterface

`default_nettype wire

/* rtl/core/bmp_pixel_row_unpacker.sv */
`default_nettype none

// Unpacks the raw pixel bytes of an uncompressed BMP image into 32-bit ARGB
// words, with blue in the low byte and alpha in the top byte. The front end
// takes one input word per cycle whenever its four-entry queue has room; it
// tracks row padding and multi-byte pixels and queues palette writes, palette
// bytes and finished direct pixels. The back end holds the palette memory
// and drains the queue one pixel per cycle, unless the output stalls, through
// its single read port, so a queued 1bpp byte is drained as up to eight
// pixels, a 4bpp byte as up to two, and every other entry is popped at once.
// Each pixel passes through the palette read register and the output register
// before it is presented. Load the palette and set the format and width
// registers before streaming data, and send a start word before each image.

module bmp_pixel_row_unpacker #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bpu_in_if.sink           item_in,
  bpu_out_if.source        pixel_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bpu_pkg::cfg_t   cfg;
  bpu_pkg::entry_t push_entry;
  bpu_pkg::entry_t head;
  logic            push;
  logic            queue_full;
  logic            head_valid;
  logic            pop;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= bpu_pkg::PIXEL_FORMAT_RESET;
      cfg.image_width  <= bpu_pkg::IMAGE_WIDTH_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == bpu_pkg::REG_PIXEL_FORMAT) begin
        cfg.pixel_format <= pwdata[2:0];
      end else begin
        cfg.image_width <= pwdata[12:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bpu_pkg::REG_IMAGE_WIDTH) begin
      prdata = {19'h00000, cfg.image_width};
    end else begin
      prdata = {29'h00000000, cfg.pixel_format};
    end
  end

  bpu_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_in    (item_in),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bpu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pixel_out  (pixel_out)
  );

endmodule

`default_nettype wire

/* rtl/core/bpu_front.sv */
`default_nettype none

module bpu_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bpu_pkg::cfg_t   cfg,
  bpu_in_if.sink               item_in,
  input  wire logic            queue_full,
  output logic                 push,
  output bpu_pkg::entry_t      push_entry
);

  localparam int PCW = $clog2(MAX_WIDTH + 1);
  localparam int RBW = $clog2(4 * MAX_WIDTH + 1);

  logic [RBW-1:0] row_byte_count, row_byte_count_next;
  logic [PCW-1:0] row_pixel_count, row_pixel_count_next;
  logic [1:0]     pixel_byte_count, pixel_byte_count_next;
  logic [23:0]    partial_pixel, partial_pixel_next;
  logic           alpha_flag, alpha_flag_next;

  logic [2:0]     fmt;
  logic [31:0]    w_ext;
  logic [PCW-1:0] width;
  logic [RBW-1:0] wr;
  logic [RBW-1:0] data_bytes;
  logic [RBW-1:0] padded;
  logic [RBW-1:0] rbc_inc;
  logic [PCW-1:0] avail;
  logic [3:0]     per;
  logic [3:0]     n;
  logic [1:0]     last_byte;
  logic [31:0]    value;
  logic [15:0]    w16;
  logic           accept;

  assign item_in.ready = !queue_full;
  assign accept = item_in.valid && !queue_full;

  always_comb begin
    fmt = (cfg.pixel_format > bpu_pkg::FMT_32BPP) ? bpu_pkg::FMT_32BPP : cfg.pixel_format;
    w_ext = 32'(cfg.image_width);
    if (w_ext == 32'd0) begin
      width = PCW'(1);
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      width = PCW'(MAX_WIDTH);
    end else begin
      width = PCW'(w_ext);
    end
    wr = RBW'(width);
    unique case (fmt)
      bpu_pkg::FMT_1BPP:  data_bytes = (wr + RBW'(7)) >> 3;
      bpu_pkg::FMT_4BPP:  data_bytes = (wr + RBW'(1)) >> 1;
      bpu_pkg::FMT_8BPP:  data_bytes = wr;
      bpu_pkg::FMT_16BPP: data_bytes = wr << 1;
      bpu_pkg::FMT_24BPP: data_bytes = (wr << 1) + wr;
      default:            data_bytes = wr << 2;
    endcase
    padded = (data_bytes + RBW'(3)) & ~RBW'(3);
    rbc_inc = row_byte_count + RBW'(1);
    avail = (row_pixel_count < width) ? (width - row_pixel_count) : '0;
    unique case (fmt)
      bpu_pkg::FMT_1BPP: per = 4'd8;
      bpu_pkg::FMT_4BPP: per = 4'd2;
      default:           per = 4'd1;
    endcase
    n = (avail < PCW'(per)) ? avail[3:0] : per;
    unique case (fmt)
      bpu_pkg::FMT_16BPP: last_byte = 2'd1;
      bpu_pkg::FMT_24BPP: last_byte = 2'd2;
      default:            last_byte = 2'd3;
    endcase
    w16 = {item_in.data_byte, partial_pixel[7:0]};
    unique case (fmt)
      bpu_pkg::FMT_16BPP: value = {8'h00, w16[14:10], 3'b000, w16[9:5], 3'b000,
                                   w16[4:0], 3'b000};
      bpu_pkg::FMT_24BPP: value = {8'h00, item_in.data_byte, partial_pixel[15:0]};
      default:            value = {item_in.data_byte, partial_pixel};
    endcase
  end

  always_comb begin
    row_byte_count_next   = row_byte_count;
    row_pixel_count_next  = row_pixel_count;
    pixel_byte_count_next = pixel_byte_count;
    partial_pixel_next    = partial_pixel;
    alpha_flag_next       = alpha_flag;
    push                  = 1'b0;
    push_entry.kind       = bpu_pkg::KIND_PAL_WRITE;
    push_entry.fmt        = fmt[1:0];
    push_entry.count      = 4'd1;
    push_entry.row_end    = 1'b0;
    push_entry.alpha      = alpha_flag;
    push_entry.addr       = item_in.palette_index;
    push_entry.data       = item_in.palette_word;
    if (accept) begin
      unique case (item_in.mode)
        bpu_pkg::MODE_PAL_WRITE: begin
          push = 1'b1;
        end
        bpu_pkg::MODE_START: begin
          row_byte_count_next   = '0;
          row_pixel_count_next  = '0;
          pixel_byte_count_next = '0;
          partial_pixel_next    = '0;
          alpha_flag_next       = 1'b0;
        end
        bpu_pkg::MODE_DATA: begin
          if (row_byte_count < data_bytes) begin
            if (fmt < bpu_pkg::FMT_16BPP) begin
              if (n != 4'd0) begin
                push               = 1'b1;
                push_entry.kind    = bpu_pkg::KIND_PAL_PIX;
                push_entry.count   = n;
                push_entry.row_end = (row_pixel_count + PCW'(n)) == width;
                push_entry.data    = {24'h000000, item_in.data_byte};
                row_pixel_count_next = row_pixel_count + PCW'(n);
              end
            end else if (pixel_byte_count >= last_byte) begin
              if (fmt == bpu_pkg::FMT_32BPP && item_in.data_byte != 8'h00) begin
                alpha_flag_next = 1'b1;
              end
              if (row_pixel_count < width) begin
                push                 = 1'b1;
                push_entry.kind      = bpu_pkg::KIND_DIRECT;
                push_entry.row_end   = row_pixel_count == (width - PCW'(1));
                push_entry.alpha     = alpha_flag_next;
                push_entry.data      = value;
                row_pixel_count_next = row_pixel_count + PCW'(1);
              end
              pixel_byte_count_next = '0;
              partial_pixel_next    = '0;
            end else begin
              partial_pixel_next = partial_pixel |
                                   (24'(item_in.data_byte) << {pixel_byte_count, 3'b000});
              pixel_byte_count_next = pixel_byte_count + 2'd1;
            end
          end
          row_byte_count_next = rbc_inc;
          if (rbc_inc >= padded) begin
            row_byte_count_next   = '0;
            row_pixel_count_next  = '0;
            pixel_byte_count_next = '0;
            partial_pixel_next    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_count   <= '0;
      row_pixel_count  <= '0;
      pixel_byte_count <= '0;
      partial_pixel    <= '0;
      alpha_flag       <= 1'b0;
    end else begin
      row_byte_count   <= row_byte_count_next;
      row_pixel_count  <= row_pixel_count_next;
      pixel_byte_count <= pixel_byte_count_next;
      partial_pixel    <= partial_pixel_next;
      alpha_flag       <= alpha_flag_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bpu_queue.sv */
`default_nettype none

module bpu_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bpu_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output bpu_pkg::entry_t       head
);

  bpu_pkg::entry_t slots [bpu_pkg::QUEUE_DEPTH];

  logic [bpu_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [bpu_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [bpu_pkg::QUEUE_AW:0]   count;
  logic                         do_pop;

  assign full       = count == (bpu_pkg::QUEUE_AW + 1)'(bpu_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bpu_pkg::QUEUE_AW'(bpu_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + bpu_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bpu_pkg::QUEUE_AW'(bpu_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + bpu_pkg::QUEUE_AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + (bpu_pkg::QUEUE_AW + 1)'(1);
      end else if (!push && do_pop) begin
        count <= count - (bpu_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bpu_back.sv */
`default_nettype none

module bpu_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire bpu_pkg::entry_t  head,
  output logic                  pop,
  bpu_out_if.source             pixel_out
);

  localparam int PIW = $clog2(PALETTE_DEPTH);

  logic [31:0] palette [PALETTE_DEPTH];

  logic [2:0]     sub;
  logic           last_sub;
  logic [7:0]     idx;
  logic           idx_ok;
  logic           waddr_ok;
  logic           issue;
  logic           is_pix;

  logic           s1_valid;
  logic           s1_pal;
  logic           s1_in_range;
  logic [31:0]    s1_data;
  logic           s1_row_end;
  logic           s1_last;
  logic           s1_alpha;
  logic [31:0]    rd_data;
  logic           s1_adv;

  logic           o_valid;
  logic [31:0]    o_pixel;
  logic           o_row_end;
  logic           o_last;
  logic           o_alpha;

  always_comb begin
    unique case (head.fmt)
      bpu_pkg::FMT_1BPP[1:0]: idx = {7'b0000000, head.data[3'd7 - sub]};
      bpu_pkg::FMT_4BPP[1:0]: idx = sub[0] ? {4'h0, head.data[3:0]} : {4'h0, head.data[7:4]};
      default:                idx = head.data[7:0];
    endcase
    idx_ok   = {1'b0, idx} < 9'(PALETTE_DEPTH);
    waddr_ok = {1'b0, head.addr} < 9'(PALETTE_DEPTH);
    last_sub = {1'b0, sub} == (head.count - 4'd1);
    s1_adv   = s1_valid && (!o_valid || pixel_out.ready);
    issue    = head_valid && (!s1_valid || s1_adv);
    is_pix   = head.kind != bpu_pkg::KIND_PAL_WRITE;
    pop      = issue && (head.kind != bpu_pkg::KIND_PAL_PIX || last_sub);
  end

  always_ff @(posedge clk) begin
    if (issue && head.kind == bpu_pkg::KIND_PAL_WRITE && waddr_ok) begin
      palette[head.addr[PIW-1:0]] <= head.data;
    end
    if (issue) begin
      rd_data <= palette[idx[PIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub      <= '0;
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (pop) begin
        sub <= '0;
      end else if (issue) begin
        sub <= sub + 3'd1;
      end
      if (issue) begin
        s1_valid <= is_pix;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        o_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pal      <= head.kind == bpu_pkg::KIND_PAL_PIX;
      s1_in_range <= idx_ok;
      s1_data     <= head.data;
      s1_last     <= head.kind != bpu_pkg::KIND_PAL_PIX || last_sub;
      s1_row_end  <= head.row_end && (head.kind != bpu_pkg::KIND_PAL_PIX || last_sub);
      s1_alpha    <= head.alpha;
    end
    if (s1_adv) begin
      o_pixel   <= s1_pal ? (s1_in_range ? rd_data : 32'h0000_0000) : s1_data;
      o_row_end <= s1_row_end;
      o_last    <= s1_last;
      o_alpha   <= s1_alpha;
    end
  end

  assign pixel_out.valid        = o_valid;
  assign pixel_out.pixel_argb   = o_pixel;
  assign pixel_out.row_end      = o_row_end;
  assign pixel_out.last_of_item = o_last;
  assign pixel_out.alpha_seen   = o_alpha;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] MODE_PAL_WRITE = bpu_pkg::MODE_PAL_WRITE;
  localparam logic [1:0] MODE_DATA      = bpu_pkg::MODE_DATA;
  localparam logic [1:0] MODE_START     = bpu_pkg::MODE_START;

  localparam logic [2:0] FMT_1BPP  = bpu_pkg::FMT_1BPP;
  localparam logic [2:0] FMT_4BPP  = bpu_pkg::FMT_4BPP;
  localparam logic [2:0] FMT_8BPP  = bpu_pkg::FMT_8BPP;
  localparam logic [2:0] FMT_16BPP = bpu_pkg::FMT_16BPP;
  localparam logic [2:0] FMT_24BPP = bpu_pkg::FMT_24BPP;
  localparam logic [2:0] FMT_32BPP = bpu_pkg::FMT_32BPP;

  localparam logic REG_PIXEL_FORMAT = bpu_pkg::REG_PIXEL_FORMAT;
  localparam logic REG_IMAGE_WIDTH  = bpu_pkg::REG_IMAGE_WIDTH;

  localparam logic [2:0]  PIXEL_FORMAT_RESET = bpu_pkg::PIXEL_FORMAT_RESET;
  localparam logic [12:0] IMAGE_WIDTH_RESET  = bpu_pkg::IMAGE_WIDTH_RESET;

  localparam int MAX_WIDTH = 4096;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_LEN = 26;
  localparam int PRESSURE_PHASE = 3;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] FMT_SPARE_6 = 3'd6;
  localparam logic [2:0] FMT_SPARE_7 = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  typedef struct packed {
    logic [31:0] argb;
    logic        row_end;
    logic        last;
    logic        alpha;
  } pixel_t;

  typedef struct packed {
    logic        is_reg;
    logic        reg_sel;
    logic [12:0] reg_val;
    logic [1:0]  mode;
    logic [7:0]  pidx;
    logic [31:0] pword;
    logic [7:0]  dbyte;
    logic        typed;
    logic [31:0] exp_argb;
    logic        exp_row_end;
    logic        exp_alpha;
  } step_t;

  localparam step_t PLAN [34] = '{
    '{1'b0, 1'b0, 13'd0, MODE_START, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h11, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h22, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h33, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h80, 1'b1, 32'h80332211, 1'b1, 1'b1},
    '{1'b0, 1'b0, 13'd0, MODE_UNUSED, 8'hFF, 32'hFFFFFFFF, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_PAL_WRITE, 8'h00, 32'h00000000, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_PAL_WRITE, 8'h01, 32'hFFFFFFFF, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_PAL_WRITE, 8'h0F, 32'h12345678, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_PAL_WRITE, 8'hFF, 32'hA5C35A3C, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, REG_PIXEL_FORMAT, 13'(FMT_1BPP), MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{1'b1, REG_IMAGE_WIDTH, 13'd8, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_START, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hAA, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, REG_PIXEL_FORMAT, 13'(FMT_8BPP), MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{1'b1, REG_IMAGE_WIDTH, 13'd1, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hFF, 1'b1, 32'hA5C35A3C, 1'b1, 1'b0},
    '{1'b1, REG_PIXEL_FORMAT, 13'(FMT_4BPP), MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{1'b1, REG_IMAGE_WIDTH, 13'd3, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hF1, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h0F, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, REG_PIXEL_FORMAT, 13'(FMT_16BPP), MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{1'b1, REG_IMAGE_WIDTH, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'hFF, 1'b1, 32'h00F8F8F8, 1'b1, 1'b0},
    '{1'b1, REG_PIXEL_FORMAT, 13'(FMT_24BPP), MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0,
      1'b0, 1'b0},
    '{1'b1, REG_IMAGE_WIDTH, 13'd4096, MODE_DATA, 8'h00, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0,
      1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h01, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h02, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 13'd0, MODE_DATA, 8'h00, 32'h0, 8'h03, 1'b0, 32'h0, 1'b0, 1'b0}
  };

  localparam logic [2:0] PH_FMT [12] = '{FMT_32BPP, FMT_1BPP, FMT_4BPP, FMT_8BPP, FMT_16BPP,
    FMT_24BPP, FMT_SPARE_6, FMT_SPARE_7, FMT_1BPP, FMT_32BPP, FMT_4BPP, FMT_16BPP};
  localparam logic [12:0] PH_WIDTH [12] = '{13'd3, 13'd13, 13'd5, 13'd7, 13'd1, 13'd6, 13'd0,
    13'd2, 13'd4096, 13'd8191, 13'd9, 13'd3};
  localparam idle_t PH_IDLE [12] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
    IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND, IDLE_BOTH, IDLE_RECV};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bpu_in_if  item_if ();
  bpu_out_if pix_if ();

  bmp_pixel_row_unpacker #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (256)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_if),
    .pixel_out (pix_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the block's state, advanced as each word is accepted.
  logic [31:0] palette [256];
  bit          palette_loaded [256];
  int unsigned row_bytes;
  int unsigned row_pix;
  int unsigned pix_bytes;
  logic [23:0] partial;
  logic        alpha_flag;
  logic [2:0]  cfg_fmt;
  logic [12:0] cfg_width;

  pixel_t pending_pixels [$];
  int     send_idle_pct;
  int     recv_stall_pct;
  int     error_count = 0;
  int     words_sent;
  int     reg_writes;
  int     pixels_seen = 0;
  int     row_ends_seen = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned eff_width();
    if (cfg_width == 13'd0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int unsigned fmt_bits();
    case (cfg_fmt)
      FMT_1BPP:  return 1;
      FMT_4BPP:  return 4;
      FMT_8BPP:  return 8;
      FMT_16BPP: return 16;
      FMT_24BPP: return 24;
      default:   return 32;
    endcase
  endfunction

  function automatic int unsigned padded_row_len();
    return (((eff_width() * fmt_bits() + 7) / 8) + 3) & ~32'd3;
  endfunction

  function automatic void clear_row();
    row_bytes = 0;
    row_pix = 0;
    pix_bytes = 0;
    partial = '0;
  endfunction

  // Returns the number of pixels the word produces and queues them.
  function automatic int decode_word(input logic [1:0] mode, input logic [7:0] pidx,
                                     input logic [31:0] pword, input logic [7:0] dbyte);
    int unsigned width, bpp, data_bytes, padded, idx, s;
    logic [31:0] argb;
    logic [15:0] w16;
    pixel_t made [$];
    width = eff_width();
    bpp = fmt_bits();
    data_bytes = (width * bpp + 7) / 8;
    padded = padded_row_len();
    case (mode)
      MODE_PAL_WRITE: begin
        palette[pidx] = pword;
        palette_loaded[pidx] = 1'b1;
        return 0;
      end
      MODE_START: begin
        clear_row();
        alpha_flag = 1'b0;
        return 0;
      end
      MODE_DATA: ;
      default: return 0;
    endcase
    if (row_bytes < data_bytes) begin
      if (bpp < 16) begin
        for (s = 0; s < 8 / bpp && row_pix < width; s++) begin
          idx = (dbyte >> (8 - bpp * (s + 1))) & ((1 << bpp) - 1);
          made.push_back('{palette[idx], row_pix == width - 1, 1'b0, 1'b0});
          row_pix++;
        end
      end else if (pix_bytes >= bpp / 8 - 1) begin
        if (bpp == 16) begin
          w16 = {dbyte, partial[7:0]};
          argb = {8'h00, w16[14:10], 3'b000, w16[9:5], 3'b000, w16[4:0], 3'b000};
        end else if (bpp == 24) begin
          argb = {8'h00, dbyte, partial[15:0]};
        end else begin
          argb = {dbyte, partial};
          if (dbyte != 8'h00) alpha_flag = 1'b1;
        end
        if (row_pix < width) begin
          made.push_back('{argb, row_pix == width - 1, 1'b0, 1'b0});
          row_pix++;
        end
        pix_bytes = 0;
        partial = '0;
      end else begin
        partial = partial | (24'(dbyte) << (8 * pix_bytes));
        pix_bytes = (pix_bytes + 1) % 4;
      end
    end
    row_bytes++;
    if (row_bytes >= padded) clear_row();
    foreach (made[k]) begin
      made[k].last = (k == made.size() - 1);
      made[k].alpha = alpha_flag;
      pending_pixels.push_back(made[k]);
    end
    return made.size();
  endfunction

  task automatic push_word(input logic [1:0] mode, input logic [7:0] pidx,
                           input logic [31:0] pword, input logic [7:0] dbyte,
                           input logic typed, input pixel_t typed_px);
    int n;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.mode <= mode;
    item_if.palette_index <= pidx;
    item_if.palette_word <= pword;
    item_if.data_byte <= dbyte;
    do @(posedge clk); while (!item_if.ready);
    n = decode_word(mode, pidx, pword, dbyte);
    if (typed) begin
      repeat (n) void'(pending_pixels.pop_back());
      pending_pixels.push_back(typed_px);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [12:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_PIXEL_FORMAT) cfg_fmt = value[2:0];
    else cfg_width = value;
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    pix_if.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_argb %h", pix_if.pixel_argb);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.pixel_argb !== want.argb) begin
          $error("pixel_argb: expected %h, got %h", want.argb, pix_if.pixel_argb);
          error_count++;
        end
        if (pix_if.row_end !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, pix_if.row_end);
          error_count++;
        end
        if (pix_if.last_of_item !== want.last) begin
          $error("last_of_item: expected %b, got %b", want.last, pix_if.last_of_item);
          error_count++;
        end
        if (pix_if.alpha_seen !== want.alpha) begin
          $error("alpha_seen: expected %b, got %b", want.alpha, pix_if.alpha_seen);
          error_count++;
        end
        pixels_seen++;
        if (want.row_end) row_ends_seen++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int ph, n_phase, nbytes, pick;
    int unsigned bpp, idx, s;
    logic [7:0] b;
    bit paused;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.mode = MODE_START;
    item_if.palette_index = '0;
    item_if.palette_word = '0;
    item_if.data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    reg_writes = 0;
    paused = 1'b0;
    cfg_fmt = PIXEL_FORMAT_RESET;
    cfg_width = IMAGE_WIDTH_RESET;
    alpha_flag = 1'b0;
    clear_row();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_reg) begin
        wait_drained();
        write_reg(PLAN[i].reg_sel, PLAN[i].reg_val);
      end else begin
        push_word(PLAN[i].mode, PLAN[i].pidx, PLAN[i].pword, PLAN[i].dbyte, PLAN[i].typed,
                  '{PLAN[i].exp_argb, PLAN[i].exp_row_end, 1'b1, PLAN[i].exp_alpha});
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      wait_drained();
      send_idle_pct = (PH_IDLE[ph] == IDLE_SEND) ? 74 : (PH_IDLE[ph] == IDLE_BOTH) ? 26 : 0;
      recv_stall_pct = (PH_IDLE[ph] == IDLE_RECV) ? 74 : (PH_IDLE[ph] == IDLE_BOTH) ? 26 : 0;
      write_reg(REG_PIXEL_FORMAT, 13'(PH_FMT[ph]));
      write_reg(REG_IMAGE_WIDTH, PH_WIDTH[ph]);
      n_phase = 0;
      while (n_phase < PHASE_LEN) begin
        if (ph == PRESSURE_PHASE && !paused && n_phase >= PHASE_LEN / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          push_word(MODE_PAL_WRITE, 8'($urandom), $urandom, 8'($urandom), 1'b0, '0);
          n_phase++;
        end else if (pick < 9) begin
          push_word(MODE_UNUSED, 8'($urandom), $urandom, 8'($urandom), 1'b0, '0);
        end else if (pick < 12) begin
          push_word(MODE_START, 8'($urandom), $urandom, 8'($urandom), 1'b0, '0);
          n_phase++;
        end else begin
          if (pick >= 20) begin
            push_word(MODE_START, 8'($urandom), $urandom, 8'($urandom), 1'b0, '0);
            n_phase++;
          end
          nbytes = padded_row_len() * $urandom_range(1, 3);
          if (nbytes > 48) nbytes = $urandom_range(8, 48);
          repeat (nbytes) begin
            b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            bpp = fmt_bits();
            // Palette entries are loaded before any byte that could select them.
            if (bpp < 16) begin
              for (s = 0; s < 8 / bpp; s++) begin
                idx = (b >> (8 - bpp * (s + 1))) & ((1 << bpp) - 1);
                if (!palette_loaded[idx]) begin
                  push_word(MODE_PAL_WRITE, 8'(idx), $urandom, 8'($urandom), 1'b0, '0);
                  n_phase++;
                end
              end
            end
            push_word(MODE_DATA, 8'($urandom), $urandom, b, 1'b0, '0);
            n_phase++;
          end
        end
      end
    end

    wait_drained();
    $display("Drove %0d words through %0d register writes, covering all six formats,",
             words_sent, reg_writes);
    $display("both unused formats and width extremes; %0d pixels checked, %0d row ends.",
             pixels_seen, row_ends_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
